/* design/sapm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the servo angle to pulse mapper.
// Used by the front, the queue, the back and the top level.
package sapm_pkg;

	localparam int CAL_W   = 45;
	localparam int IDX_W   = 3;
	localparam int PROD_W  = 20;
	localparam int CNT_W   = 5;

	localparam logic [7:0] ANGLE_LIMIT = 8'd180;

	localparam logic OP_ONE = 1'b0;
	localparam logic OP_ALL = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_CH    = 2'd1,
		ST_BAD_ANGLE = 2'd2,
		ST_BAD_CAL   = 2'd3
	} status_t;

	// One per-channel job handed from the front to the back.
	typedef struct packed {
		logic [7:0] lch;
		logic [7:0] angle;
		status_t    status;
		logic       last;
	} job_t;

	// One finished result beat.
	typedef struct packed {
		logic [7:0]  lch;
		logic [3:0]  och;
		logic [11:0] pulse;
		status_t     status;
		logic        last;
	} res_t;

	// Unpacked calibration word.
	typedef struct packed {
		logic [3:0]  och;
		logic [11:0] pmax;
		logic [11:0] pmin;
		logic        rev;
		logic [7:0]  amax;
		logic [7:0]  amin;
	} cal_t;

endpackage

/* design/sapm_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands and results.
// Depends on nothing but plain logic types.
interface sapm_cmd_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] target_channel;
	logic [7:0] angle;

	modport source (output valid, opcode, target_channel, angle, input ready);
	modport sink   (input valid, opcode, target_channel, angle, output ready);
endinterface

interface sapm_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  logical_channel;
	logic [3:0]  output_channel;
	logic [11:0] pulse_width;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, logical_channel, output_channel, pulse_width, status, last,
		input ready);
	modport sink   (input valid, logical_channel, output_channel, pulse_width, status, last,
		output ready);
endinterface

/* design/sapm_front.sv */
`timescale 1ns / 1ps
// Command front end: accepts a command, checks channel and angle, and
// expands it into per-channel jobs. Depends on sapm_pkg and sapm_if.
module sapm_front import sapm_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	sapm_cmd_if.sink        cmd,
	output logic            push,
	output job_t            job,
	input  logic            full
);

	typedef enum logic {F_IDLE, F_EMIT} fstate_t;

	localparam logic [7:0] LAST_CH = 8'(CHANNELS - 1);

	fstate_t    state_q;
	logic       all_q;
	logic [7:0] lch_q;
	logic [7:0] angle_q;
	status_t    status_q;
	logic       job_last;

	assign cmd.ready = (state_q == F_IDLE);

	// Only an error-free broadcast spans several jobs.
	assign job_last = !all_q || (lch_q == LAST_CH);
	assign job      = '{lch: lch_q, angle: angle_q, status: status_q, last: job_last};
	assign push     = (state_q == F_EMIT) && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			all_q    <= 1'b0;
			lch_q    <= '0;
			angle_q  <= '0;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (cmd.valid) begin
						angle_q <= cmd.angle;
						state_q <= F_EMIT;
						if (cmd.opcode == OP_ONE) begin
							lch_q <= cmd.target_channel;
							all_q <= 1'b0;
							if (32'(cmd.target_channel) >= CHANNELS) begin
								status_q <= ST_BAD_CH;
							end else if (cmd.angle > ANGLE_LIMIT) begin
								status_q <= ST_BAD_ANGLE;
							end else begin
								status_q <= ST_OK;
							end
						end else begin
							lch_q <= '0;
							if (cmd.angle > ANGLE_LIMIT) begin
								status_q <= ST_BAD_ANGLE;
								all_q    <= 1'b0;
							end else begin
								status_q <= ST_OK;
								all_q    <= 1'b1;
							end
						end
					end
				end
				F_EMIT: begin
					if (push) begin
						if (job_last) begin
							state_q <= F_IDLE;
						end else begin
							lch_q <= lch_q + 8'd1;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

/* design/sapm_fifo.sv */
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the mapping back end.
// Depends on sapm_pkg for the job type.
module sapm_fifo import sapm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output job_t rd_job,
	output logic empty
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/sapm_back.sv */
`timescale 1ns / 1ps
// Mapping back end: holds the calibration registers, clamps and mirrors
// the angle, multiplies once and divides serially. Depends on sapm_pkg, sapm_if.
module sapm_back import sapm_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0] cfg_data,
	output logic             pop,
	input  job_t             job,
	input  logic             empty,
	sapm_res_if.source       res
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [2:0] {B_IDLE, B_PREP, B_MUL, B_DIV, B_FIN, B_DONE} bstate_t;

	logic [CAL_W-1:0] cal_q [CHANNELS];

	bstate_t           state_q;
	job_t              job_q;
	res_t              work_q;
	res_t              out_q;
	logic              out_valid_q;
	logic [7:0]        d_q;
	logic [7:0]        span_q;
	logic [11:0]       mag_q;
	logic              neg_q;
	logic [11:0]       pmin_q;
	logic [PROD_W-1:0] quo_q;
	logic [7:0]        rem_q;
	logic [CNT_W-1:0]  cnt_q;

	cal_t              cal;
	logic [7:0]        a_clamp;
	logic [12:0]       delta;
	logic [8:0]        rem_shift;
	logic              sub_ok;
	logic [8:0]        rem_sub;
	logic [12:0]       pulse_sum;
	logic              out_free;
	logic              load_out;

	assign pop      = (state_q == B_IDLE) && !empty;
	assign out_free = !out_valid_q || res.ready;
	assign load_out = (state_q == B_DONE) && out_free;

	assign cal = cal_t'(cal_q[job_q.lch[CH_W-1:0]]);

	always_comb begin
		a_clamp = job_q.angle;
		if (a_clamp < cal.amin) begin
			a_clamp = cal.amin;
		end
		if (a_clamp > cal.amax) begin
			a_clamp = cal.amax;
		end
	end

	assign delta     = {1'b0, cal.pmax} - {1'b0, cal.pmin};
	assign rem_shift = {rem_q, quo_q[PROD_W-1]};
	assign sub_ok    = (rem_shift >= {1'b0, span_q});
	assign rem_sub   = rem_shift - {1'b0, span_q};
	assign pulse_sum = neg_q ? ({1'b0, pmin_q} - {1'b0, quo_q[11:0]})
	                         : ({1'b0, pmin_q} + {1'b0, quo_q[11:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cal_q[i] <= '0;
			end
		end else if (cfg_we && (32'(cfg_index) < CHANNELS)) begin
			cal_q[cfg_index[CH_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			job_q       <= '0;
			work_q      <= '0;
			out_q       <= '0;
			d_q         <= '0;
			span_q      <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			pmin_q      <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						job_q         <= job;
						work_q.lch    <= job.lch;
						work_q.och    <= '0;
						work_q.pulse  <= '0;
						work_q.status <= job.status;
						work_q.last   <= job.last;
						state_q       <= (job.status == ST_OK) ? B_PREP : B_DONE;
					end
				end
				B_PREP: begin
					if (cal.amin > cal.amax) begin
						work_q.status <= ST_BAD_CAL;
						state_q       <= B_DONE;
					end else begin
						work_q.och <= cal.och;
						d_q        <= cal.rev ? (cal.amax - a_clamp) : (a_clamp - cal.amin);
						span_q     <= cal.amax - cal.amin;
						neg_q      <= delta[12];
						mag_q      <= delta[12] ? 12'(-delta) : delta[11:0];
						pmin_q     <= cal.pmin;
						if (cal.amax == cal.amin) begin
							work_q.pulse <= cal.pmin;
							state_q      <= B_DONE;
						end else begin
							state_q <= B_MUL;
						end
					end
				end
				B_MUL: begin
					quo_q   <= PROD_W'(d_q) * PROD_W'(mag_q);
					rem_q   <= '0;
					cnt_q   <= CNT_W'(PROD_W - 1);
					state_q <= B_DIV;
				end
				B_DIV: begin
					// Restoring division, one quotient bit per cycle.
					quo_q <= {quo_q[PROD_W-2:0], sub_ok};
					rem_q <= sub_ok ? rem_sub[7:0] : rem_shift[7:0];
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					work_q.pulse <= pulse_sum[11:0];
					state_q      <= B_DONE;
				end
				B_DONE: begin
					if (out_free) begin
						out_q   <= work_q;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign res.valid           = out_valid_q;
	assign res.logical_channel = out_q.lch;
	assign res.output_channel  = out_q.och;
	assign res.pulse_width     = out_q.pulse;
	assign res.status          = out_q.status;
	assign res.last            = out_q.last;

endmodule

/* design/servo_angle_to_pulse_mapper_top.sv */
`timescale 1ns / 1ps
// Servo angle to pulse mapper, top level. Depends on sapm_pkg, sapm_if,
// sapm_front, sapm_fifo and sapm_back.
//
// The block takes commands that set one logical servo channel or all
// CHANNELS channels to an angle, and returns one result beat per addressed
// channel (or a single error beat), the final beat of a command marked by
// last. Each channel has a 45-bit calibration register written through the
// plain cfg port (index i is channel i, writes to indexes at or beyond
// CHANNELS are dropped); it holds the angle window, the reverse bit, the
// pulse range and the physical output channel, and resets to zero. The
// angle is clamped into the window, mirrored when reversed, and mapped
// linearly onto the pulse range with truncation toward zero. A front end
// checks and expands commands into jobs, a two-entry queue buffers them,
// and a back end computes each job with one 8x12 multiply and a restoring
// divider that yields one quotient bit per cycle. A mapped channel passes
// through fetch, prepare, multiply, 20 divide steps, final add and output
// load; equal window limits or a bad calibration skip the multiply and
// divide, and a rejected command goes from fetch straight to output load.
// A job is fetched only once the last one is loaded for output. A new
// command is accepted once every job of the previous one is queued.

module servo_angle_to_pulse_mapper_top import sapm_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0] cfg_data,
	sapm_cmd_if.sink         cmd,
	sapm_res_if.source       res
);

	// Jobs from the front end into the queue.
	logic push;
	job_t wr_job;
	logic full;

	// Jobs from the queue into the back end.
	logic pop;
	job_t rd_job;
	logic empty;

	sapm_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.push   (push),
		.job    (wr_job),
		.full   (full)
	);

	sapm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty)
	);

	sapm_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pop       (pop),
		.job       (rd_job),
		.empty     (empty),
		.res       (res)
	);

endmodule

/* tb/sv/sapm_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the servo angle to pulse mapper: predicts the beats of each command.
// Depends on sapm_pkg and on the sapm_cmd_if and sapm_res_if interfaces.
module sapm_result_checker import sapm_pkg::*; #(
	parameter int NUM_CH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0] cfg_data,
	sapm_cmd_if              cmd,
	sapm_res_if              res,
	output int               mismatches,
	output int               pending,
	output int               beats_seen
);

	cal_t cal_copy [NUM_CH];
	res_t expected_beats [$];
	int   mismatch_cnt = 0;
	int   beat_cnt = 0;

	// Clamp, optionally mirror, then map linearly; division truncates toward zero.
	function automatic res_t pulse_for_channel(input int idx, input logic [7:0] ang,
		input logic last);
		cal_t c;
		res_t r;
		int   lo, hi, a, phys, pulse;
		c = cal_copy[idx];
		lo = c.amin;
		hi = c.amax;
		r.lch = 8'(idx);
		r.last = last;
		r.och = '0;
		r.pulse = '0;
		if (lo > hi) begin
			r.status = ST_BAD_CAL;
			return r;
		end
		a = ang;
		if (a < lo) a = lo;
		if (a > hi) a = hi;
		phys = c.rev ? (hi - (a - lo)) : a;
		pulse = int'(c.pmin);
		if (hi != lo)
			pulse = (phys - lo) * (int'(c.pmax) - int'(c.pmin)) / (hi - lo) + int'(c.pmin);
		r.och = c.och;
		r.pulse = 12'(pulse);
		r.status = ST_OK;
		return r;
	endfunction

	function automatic void predict_command(input logic op, input logic [7:0] ch,
		input logic [7:0] ang);
		res_t r;
		r = '0;
		r.last = 1'b1;
		if (op == OP_ONE) begin
			r.lch = ch;
			if (ch >= NUM_CH) begin
				r.status = ST_BAD_CH;
				expected_beats.push_back(r);
			end else if (ang > ANGLE_LIMIT) begin
				r.status = ST_BAD_ANGLE;
				expected_beats.push_back(r);
			end else begin
				expected_beats.push_back(pulse_for_channel(int'(ch), ang, 1'b1));
			end
		end else if (ang > ANGLE_LIMIT) begin
			r.status = ST_BAD_ANGLE;
			expected_beats.push_back(r);
		end else begin
			for (int i = 0; i < NUM_CH; i++)
				expected_beats.push_back(pulse_for_channel(i, ang, i == NUM_CH - 1));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		res_t got, want;
		if (!arst_n) begin
			foreach (cal_copy[i]) cal_copy[i] = '0;
			expected_beats.delete();
		end else begin
			if (cfg_we && cfg_index < NUM_CH)
				cal_copy[cfg_index] = cal_t'(cfg_data);
			if (res.valid && res.ready) begin
				got.lch = res.logical_channel;
				got.och = res.output_channel;
				got.pulse = res.pulse_width;
				got.status = status_t'(res.status);
				got.last = res.last;
				beat_cnt++;
				if (expected_beats.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("%0t: unexpected beat lch=%0d och=%0d pulse=%0d st=%0d last=%0d",
							$realtime, got.lch, got.och, got.pulse, got.status, got.last);
					mismatch_cnt++;
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						if (mismatch_cnt < 10) begin
							$display("%0t: beat mismatch, expected lch=%0d och=%0d pulse=%0d",
								$realtime, want.lch, want.och, want.pulse);
							$display("    expected st=%0d last=%0d, got lch=%0d och=%0d",
								want.status, want.last, got.lch, got.och);
							$display("    got pulse=%0d st=%0d last=%0d",
								got.pulse, got.status, got.last);
						end
						mismatch_cnt++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				predict_command(cmd.opcode, cmd.target_channel, cmd.angle);
		end
		mismatches <= mismatch_cnt;
		pending <= expected_beats.size();
		beats_seen <= beat_cnt;
	end

endmodule

/* tb/sv/servo_angle_to_pulse_mapper_top_test.sv */
`timescale 1ns / 1ps
// Test bench top for the servo angle to pulse mapper: clock, reset, calibration and stimulus.
// Depends on sapm_pkg, the sapm interfaces, sapm_result_checker and the block's top level.
module servo_angle_to_pulse_mapper_top_test;
	import sapm_pkg::*;

	localparam int NUM_CH = 8;
	// Longest stretch without any handshake is about one mapped channel plus
	// the longest stall on either side; this limit is many times that.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_SLACK = 4;
	localparam int END_SLACK = 40;
	localparam int RANDOM_SETS = 6;
	localparam int ITEMS_PER_SET = 76;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CAL_W-1:0] cfg_data;

	sapm_cmd_if cmd_ch ();
	sapm_res_if res_ch ();

	int   mismatches, pending, beats_seen;
	int   idle_cycles = 0;
	int   n_cmds = 0;
	int   n_bcast = 0;
	int   n_sets = 0;
	bit   calm = 1'b0;
	cal_t next_cal [NUM_CH];

	servo_angle_to_pulse_mapper_top #(.CHANNELS(NUM_CH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	// The checker sees everything the block sees and reports failures back here.
	sapm_result_checker #(.NUM_CH(NUM_CH)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.beats_seen (beats_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Gap lengths: mostly none, some short, a few long. A calm set runs without gaps.
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic cal_t make_cal(input int amin, input int amax, input bit rev,
		input int pmin, input int pmax, input int och);
		cal_t c;
		c.amin = 8'(amin);
		c.amax = 8'(amax);
		c.rev = rev;
		c.pmin = 12'(pmin);
		c.pmax = 12'(pmax);
		c.och = 4'(och);
		return c;
	endfunction

	// Most windows are sane; some are a single angle, some are inverted (a bad
	// calibration) and some use the full byte range beyond the angle limit.
	function automatic cal_t random_cal();
		cal_t c;
		int   pick, lo, hi;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			lo = $urandom_range(0, 180);
			hi = $urandom_range(lo, 180);
		end else if (pick < 65) begin
			lo = $urandom_range(0, 180);
			hi = lo;
		end else if (pick < 80) begin
			hi = $urandom_range(0, 254);
			lo = $urandom_range(hi + 1, 255);
		end else begin
			lo = $urandom_range(0, 255);
			hi = $urandom_range(0, 255);
		end
		c = make_cal(lo, hi, 1'($urandom), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 15));
		return c;
	endfunction

	// Writes every calibration register back to back; called only when the block is idle.
	task automatic load_cal();
		for (int i = 0; i < NUM_CH; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data <= next_cal[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		n_sets++;
	endtask

	// Offers one command beat after a random gap and returns on the edge that takes it.
	// With no gap, valid stays high and only the payload changes.
	task automatic send_cmd(input logic op, input logic [7:0] ch, input logic [7:0] ang);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.target_channel <= ch;
		cmd_ch.angle <= ang;
		do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
		n_cmds++;
		if (op == OP_ALL) n_bcast++;
	endtask

	// Mostly single-channel commands to valid channels and angles, with a share of
	// broadcasts, out-of-range channels and angles above the limit.
	task automatic send_random_cmd();
		logic       op;
		logic [7:0] ch, ang;
		op = ($urandom_range(0, 4) == 0) ? OP_ALL : OP_ONE;
		if (op == OP_ALL)
			ch = 8'($urandom_range(0, 255));
		else if ($urandom_range(0, 6) == 0)
			ch = 8'($urandom_range(NUM_CH, 255));
		else
			ch = 8'($urandom_range(0, NUM_CH - 1));
		if ($urandom_range(0, 5) == 0)
			ang = 8'($urandom_range(181, 255));
		else
			ang = 8'($urandom_range(0, 180));
		send_cmd(op, ch, ang);
	endtask

	// The sender holds off until every predicted beat has come back. The first
	// edge is always waited out so that the checker has seen the last command.
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Result side: ready is dropped for random stretches, or never in a calm set.
	initial begin : sink_pacing
		int hold;
		hold = 0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) hold = pick_gap();
			end
		end
	end

	// Watchdog: any beat on either channel or a register write counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no progress for %0d cycles, %0d beats still due",
					idle_cycles, pending);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.opcode <= OP_ONE;
		cmd_ch.target_channel <= '0;
		cmd_ch.angle <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset calibration every window is the single angle zero and
		// every pulse range is zero.
		send_cmd(OP_ONE, 8'd0, 8'd90);
		send_cmd(OP_ALL, 8'd0, 8'd45);
		wait_drained();

		// Directed calibration: a plain servo, a reversed narrow window, a single-angle
		// window, an inverted window, a falling pulse range, all ones, all zeros, and a
		// reversed full pulse range.
		next_cal[0] = make_cal(0, 180, 1'b0, 500, 2500, 3);
		next_cal[1] = make_cal(30, 150, 1'b1, 1000, 2000, 15);
		next_cal[2] = make_cal(90, 90, 1'b0, 1500, 2500, 5);
		next_cal[3] = make_cal(100, 50, 1'b0, 700, 2300, 9);
		next_cal[4] = make_cal(0, 255, 1'b0, 4095, 0, 8);
		next_cal[5] = '1;
		next_cal[6] = '0;
		next_cal[7] = make_cal(10, 170, 1'b1, 0, 4095, 7);
		load_cal();

		send_cmd(OP_ONE, 8'd0, 8'd0);
		send_cmd(OP_ONE, 8'd0, 8'd180);
		send_cmd(OP_ONE, 8'd0, 8'd90);
		send_cmd(OP_ONE, 8'd0, 8'd181);
		send_cmd(OP_ONE, 8'd0, 8'd255);
		send_cmd(OP_ONE, 8'd8, 8'd0);
		// A bad channel is reported even when the angle is also out of range.
		send_cmd(OP_ONE, 8'd255, 8'd200);
		send_cmd(OP_ONE, 8'd1, 8'd0);
		send_cmd(OP_ONE, 8'd1, 8'd180);
		send_cmd(OP_ONE, 8'd1, 8'd100);
		send_cmd(OP_ONE, 8'd2, 8'd45);
		send_cmd(OP_ONE, 8'd3, 8'd60);
		send_cmd(OP_ONE, 8'd4, 8'd77);
		send_cmd(OP_ONE, 8'd5, 8'd180);
		send_cmd(OP_ONE, 8'd6, 8'd33);
		send_cmd(OP_ONE, 8'd7, 8'd11);
		send_cmd(OP_ALL, 8'd0, 8'd0);
		send_cmd(OP_ALL, 8'd0, 8'd180);
		send_cmd(OP_ALL, 8'd0, 8'd181);
		send_cmd(OP_ALL, 8'd255, 8'd255);
		send_cmd(OP_ALL, 8'hAA, 8'd123);
		wait_drained();

		// Random sets: all ones, all zeros, then random calibrations; one set runs
		// with no gaps on either side.
		for (int s = 0; s < RANDOM_SETS; s++) begin
			foreach (next_cal[i]) begin
				if (s == 0)
					next_cal[i] = '1;
				else if (s == 1)
					next_cal[i] = '0;
				else
					next_cal[i] = random_cal();
			end
			load_cal();
			calm = (s == 3);
			for (int n = 0; n < ITEMS_PER_SET; n++)
				send_random_cmd();
			wait_drained();
		end
		calm = 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (END_SLACK) @(posedge clk);

		$display("Covered %0d commands (%0d broadcasts) and %0d result beats over %0d calibration sets.",
			n_cmds, n_bcast, beats_seen, n_sets);
		$display("Sets included reset, all-ones, all-zero, reversed, single-angle and inverted windows.");
		if (mismatches == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatched beats, %0d still due", mismatches, pending);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
